FILE: hdl/alert_tone_sequencer_defines.svh
// ---------------------------------------------------------------------------
// Alert tone sequencer assertion macros
// Shared concurrent assertion shorthands for the tone sequencer checkers.
// ---------------------------------------------------------------------------
`ifndef ALERT_TONE_SEQUENCER_DEFINES_SVH
`define ALERT_TONE_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ATS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alert tone sequencer check failed");

// next-cycle implication, disabled while reset is asserted
`define ATS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alert tone sequencer check failed");

`endif

FILE: hdl/ats_pkg.sv
// ---------------------------------------------------------------------------
// Alert tone sequencer package
// Cue segment table, tone frequencies, fixed-point constants and the
// controller command bundle.
// ---------------------------------------------------------------------------
package ats_pkg;

  // input function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // valid cue numbers
  localparam logic [3:0] CUE_MIN = 4'd1;
  localparam logic [3:0] CUE_MAX = 4'd9;

  localparam int unsigned NUM_CUES  = 9;
  localparam int unsigned MAX_SEGS  = 5;
  localparam int unsigned NUM_TONES = 13;

  localparam int unsigned RATE_HZ = 44100;

  // gain register reset, about 0.26 in unsigned q0.16
  localparam logic [15:0] GAIN_RESET = 16'd17039;

  // fade ramp lengths in samples
  localparam logic [6:0] FADE_IN_LEN  = 7'd80;
  localparam logic [6:0] FADE_OUT_LEN = 7'd120;

  // divide by 65536*80*120: shift out 2^16 * 2^7, then divide by 75
  localparam int unsigned SCALE_SHIFT = 23;
  localparam int unsigned DIV75_SHIFT = 29;
  localparam logic [22:0] DIV75_MAGIC = 23'd7158279;

  // sine table generation constants in q2.30
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // tone code 0 is silence
  localparam logic [10:0] TONE_FREQ [NUM_TONES] = '{
    11'd0,   11'd440, 11'd466, 11'd523, 11'd554, 11'd587, 11'd622,
    11'd659, 11'd698, 11'd740, 11'd880, 11'd988, 11'd1046
  };

  typedef struct packed {
    logic [3:0]  tone;
    logic [12:0] len;
  } seg_t;

  // segments per cue
  localparam logic [2:0] CUE_LEN [NUM_CUES] = '{
    3'd4, 3'd3, 3'd5, 3'd5, 3'd5, 3'd5, 3'd3, 3'd1, 3'd5
  };

  // segment table: tone code and length in samples (ms * 44100 / 1000)
  localparam seg_t CUE_ROM [NUM_CUES][MAX_SEGS] = '{
    '{'{4'd9, 13'd3087}, '{4'd0, 13'd970}, '{4'd10, 13'd3748}, '{4'd0, 13'd793},
      '{4'd0, 13'd0}},
    '{'{4'd7, 13'd3528}, '{4'd0, 13'd1058}, '{4'd10, 13'd4851}, '{4'd0, 13'd0},
      '{4'd0, 13'd0}},
    '{'{4'd5, 13'd3087}, '{4'd0, 13'd793}, '{4'd9, 13'd3087}, '{4'd0, 13'd793},
      '{4'd11, 13'd5292}},
    '{'{4'd6, 13'd3969}, '{4'd0, 13'd1587}, '{4'd2, 13'd4851}, '{4'd0, 13'd1234},
      '{4'd2, 13'd3969}},
    '{'{4'd10, 13'd3969}, '{4'd0, 13'd1852}, '{4'd10, 13'd3969}, '{4'd0, 13'd1852},
      '{4'd8, 13'd7056}},
    '{'{4'd3, 13'd2866}, '{4'd0, 13'd793}, '{4'd7, 13'd3087}, '{4'd0, 13'd793},
      '{4'd12, 13'd5512}},
    '{'{4'd3, 13'd3969}, '{4'd0, 13'd1146}, '{4'd7, 13'd4851}, '{4'd0, 13'd0},
      '{4'd0, 13'd0}},
    '{'{4'd12, 13'd4189}, '{4'd0, 13'd0}, '{4'd0, 13'd0}, '{4'd0, 13'd0},
      '{4'd0, 13'd0}},
    '{'{4'd1, 13'd3087}, '{4'd0, 13'd793}, '{4'd4, 13'd3087}, '{4'd0, 13'd793},
      '{4'd9, 13'd6174}}
  };

  // controller to datapath commands
  typedef struct packed {
    logic tick;
    logic start;
    logic mul1;
    logic mul2;
    logic load_out;
  } ats_cmd_t;

  // quarter-wave entry from a q2.30 angle, horner taylor series to x^13
  function automatic logic [14:0] sine_q15(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (s * 64'd32767 + 64'd536870912) >> 30;
    return r[14:0];
  endfunction

endpackage

FILE: hdl/ats_in_if.sv
// ---------------------------------------------------------------------------
// Alert tone sequencer input channel
// Carries start and tick items with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface ats_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [3:0] sound;

  modport source (output valid, func, sound, input ready);
  modport sink   (input valid, func, sound, output ready);
endinterface

FILE: hdl/ats_out_if.sv
// ---------------------------------------------------------------------------
// Alert tone sequencer output channel
// Carries one pcm sample beat with its cue flags.
// ---------------------------------------------------------------------------
interface ats_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               cue_last;
  logic               playing;

  modport source (output valid, sample, cue_last, playing, input ready);
  modport sink   (input valid, sample, cue_last, playing, output ready);
endinterface

FILE: hdl/ats_cfg_if.sv
// ---------------------------------------------------------------------------
// Alert tone sequencer configuration channel
// Write channel for the amplitude gain register.
// ---------------------------------------------------------------------------
interface ats_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] amplitude_gain;

  modport source (output valid, amplitude_gain, input ready);
  modport sink   (input valid, amplitude_gain, output ready);
endinterface

FILE: hdl/ats_ctrl.sv
// ---------------------------------------------------------------------------
// Alert tone sequencer controller
// Steps a tick through the multiply chain and owns the output valid flag.
// ---------------------------------------------------------------------------
module ats_ctrl import ats_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_func_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output ats_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.tick     = in_fire && (in_func_i == FUNC_TICK);
    cmd_o.start    = in_fire && (in_func_i == FUNC_START);
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.tick) state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        // wait here while the previous beat is still unclaimed
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/ats_datapath.sv
// ---------------------------------------------------------------------------
// Alert tone sequencer datapath
// Cue sequencing state, phase accumulator, quarter-wave rom, gain and fade
// multipliers and the output sample register.
// ---------------------------------------------------------------------------
module ats_datapath import ats_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_BITS       = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ats_cmd_t           cmd_i,
  input  logic [3:0]         sound_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_gain_i,
  output logic signed [15:0] sample_o,
  output logic               cue_last_o,
  output logic               playing_o
);

  localparam int unsigned QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned OFF_W   = IDX_W - 2;
  localparam int unsigned AW      = OFF_W + 1;

  // per-tone phase increments, rounded at elaboration
  logic [PHASE_BITS-1:0] inc_tab [NUM_TONES];

  for (genvar g = 0; g < NUM_TONES; g++) begin : g_inc
    localparam logic [63:0] IncFull =
      ((64'(TONE_FREQ[g]) << PHASE_BITS) + 64'(RATE_HZ / 2)) / 64'(RATE_HZ);
    assign inc_tab[g] = IncFull[PHASE_BITS-1:0];
  end

  // quarter-wave sine rom, quarter + 1 entries
  logic [14:0] sin_tab [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_sin
    localparam logic [63:0] XQ30 =
      (64'(k) * HALF_PI_Q30 + 64'(QUARTER / 2)) / 64'(QUARTER);
    localparam logic [14:0] SinVal = sine_q15(XQ30);
    assign sin_tab[k] = SinVal;
  end

  // control state
  logic [15:0]           gain_q;
  logic [3:0]            cue_q;
  logic [2:0]            seg_q;
  logic [12:0]           sic_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic                  busy_q;

  // pipeline payload
  logic [14:0] rom_q;
  logic        neg_q;
  logic        tone_q;
  logic [6:0]  fin_q;
  logic [6:0]  fout_q;
  logic        last_q;
  logic        play_q;
  logic [30:0] m1_q;
  logic [13:0] f_q;
  logic [44:0] p_q;
  logic signed [15:0] sample_q;
  logic        cue_last_q;
  logic        playing_q;

  // current segment lookup
  logic [3:0]  cue_idx;
  seg_t        seg_cur;
  logic [2:0]  cue_segs;
  logic        tone_on;
  logic        seg_end;
  logic        cue_end;
  logic [12:0] sic_inc;
  logic [12:0] remain;
  logic [6:0]  fin;
  logic [6:0]  fout;
  logic        sound_ok;

  assign cue_idx  = (cue_q == 4'd0) ? 4'd0 : 4'(cue_q - 4'd1);
  assign seg_cur  = CUE_ROM[cue_idx][seg_q];
  assign cue_segs = CUE_LEN[cue_idx];
  assign tone_on  = busy_q && (seg_cur.tone != 4'd0);
  assign sic_inc  = 13'(sic_q + 13'd1);
  assign seg_end  = (sic_inc == seg_cur.len);
  assign cue_end  = seg_end && (seg_q == 3'(cue_segs - 3'd1));
  assign remain   = 13'(seg_cur.len - sic_q);
  assign fin      = (sic_q < 13'(FADE_IN_LEN)) ? sic_q[6:0] : FADE_IN_LEN;
  assign fout     = (remain < 13'(FADE_OUT_LEN)) ? remain[6:0] : FADE_OUT_LEN;
  assign sound_ok = (sound_i >= CUE_MIN) && (sound_i <= CUE_MAX);

  // rom address from the phase: fold the four quadrants onto the table
  logic [IDX_W-1:0] idx;
  logic [OFF_W-1:0] off;
  logic [AW-1:0]    rom_addr;

  assign idx      = phase_q[PHASE_BITS-1 -: IDX_W];
  assign off      = idx[OFF_W-1:0];
  assign rom_addr = idx[IDX_W-2] ? AW'(AW'(QUARTER) - {1'b0, off}) : {1'b0, off};

  // sequencing state and gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RESET;
      cue_q   <= 4'd0;
      seg_q   <= 3'd0;
      sic_q   <= 13'd0;
      phase_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      if (cfg_we_i) gain_q <= cfg_gain_i;
      if (cmd_i.start && sound_ok) begin
        cue_q   <= sound_i;
        seg_q   <= 3'd0;
        sic_q   <= 13'd0;
        phase_q <= '0;
        busy_q  <= 1'b1;
      end else if (cmd_i.tick && busy_q) begin
        // phase only moves during tones
        if (tone_on) phase_q <= PHASE_BITS'(phase_q + inc_tab[seg_cur.tone]);
        if (seg_end) begin
          sic_q <= 13'd0;
          if (cue_end) begin
            seg_q  <= 3'd0;
            busy_q <= 1'b0;
          end else begin
            seg_q <= 3'(seg_q + 3'd1);
          end
        end else begin
          sic_q <= sic_inc;
        end
      end
    end
  end

  // capture rom data, fades and flags for the tick
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      rom_q  <= sin_tab[rom_addr];
      neg_q  <= idx[IDX_W-1];
      tone_q <= tone_on;
      fin_q  <= fin;
      fout_q <= fout;
      last_q <= busy_q && cue_end;
      play_q <= busy_q;
    end
  end

  // gain times magnitude, fade-in times fade-out
  logic [14:0] mag;

  assign mag = tone_q ? rom_q : 15'd0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      m1_q <= 31'(mag) * 31'(gain_q);
      f_q  <= 14'(fin_q) * 14'(fout_q);
    end
  end

  // full product
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) p_q <= 45'(m1_q) * 45'(f_q);
  end

  // divide by 2^23 with a shift, then by 75 via reciprocal multiply
  logic [21:0] scaled;
  logic [44:0] quot_prod;
  logic [14:0] quot;
  logic [15:0] quot_ext;

  assign scaled    = p_q[44:SCALE_SHIFT];
  assign quot_prod = 45'(scaled) * 45'(DIV75_MAGIC);
  assign quot      = quot_prod[DIV75_SHIFT+14:DIV75_SHIFT];
  assign quot_ext  = {1'b0, quot};

  // output beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_q   <= neg_q ? -$signed(quot_ext) : $signed(quot_ext);
      cue_last_q <= last_q;
      playing_q  <= play_q;
    end
  end

  assign sample_o   = sample_q;
  assign cue_last_o = cue_last_q;
  assign playing_o  = playing_q;

endmodule

FILE: hdl/alert_tone_sequencer.sv
// ---------------------------------------------------------------------------
// Alert tone sequencer
// Plays one of nine fixed alert cues as 16-bit pcm, one sample per tick.
// ---------------------------------------------------------------------------
// A start item (func 1) selects cue 1..9, clears the phase and gives no beat;
// cue numbers outside 1..9 are dropped. Every tick item (func 0) gives one
// output beat: the sample, a flag on the last sample of the cue and a flag
// while a cue plays. An accepted tick passes through the rom read register,
// the gain/fade multiply, the full product, and the output register, which
// takes the reciprocal divide by 75 combinationally; the multiplies and the
// divide each use their own multiplier. The last stage holds for as long as
// the previous beat is still unclaimed on the output channel. The next item
// is accepted as soon as the result sits in the output register, even while
// that beat waits.
// The gain register is written through the configuration channel, which is
// always ready, and should only be written while no tick is in flight.
module alert_tone_sequencer import ats_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_BITS       = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ats_in_if.sink   tone_in,
  ats_out_if.source tone_out,
  ats_cfg_if.sink  cfg
);

  ats_cmd_t cmd;

  // configuration writes are always accepted
  assign cfg.ready = 1'b1;

  // sequencing control
  ats_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tone_in.valid),
    .in_func_i   (tone_in.func),
    .in_ready_o  (tone_in.ready),
    .out_ready_i (tone_out.ready),
    .out_valid_o (tone_out.valid),
    .cmd_o       (cmd)
  );

  // tone datapath
  ats_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sound_i    (tone_in.sound),
    .cfg_we_i   (cfg.valid),
    .cfg_gain_i (cfg.amplitude_gain),
    .sample_o   (tone_out.sample),
    .cue_last_o (tone_out.cue_last),
    .playing_o  (tone_out.playing)
  );

endmodule

FILE: hdl/ats_checker.sv
// ---------------------------------------------------------------------------
// Alert tone sequencer checker
// Port-level assertions on the sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`include "alert_tone_sequencer_defines.svh"

module ats_checker import ats_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_func_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] sample_i,
  input logic        cue_last_i,
  input logic        playing_i
);

  logic tick_fire;
  logic start_fire;

  assign tick_fire  = in_valid_i && in_ready_i && (in_func_i == FUNC_TICK);
  assign start_fire = in_valid_i && in_ready_i && (in_func_i == FUNC_START);

  // a pending beat stays up until taken
  `ATS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a tick in flight blocks the input side
  `ATS_ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, tick_fire, !in_ready_i)

  // a start never produces a beat
  `ATS_ASSERT_NEXT(a_start_quiet, clk_i, rst_ni, start_fire && !out_valid_i, !out_valid_i)

  // idle ticks are silent
  `ATS_ASSERT_NOW(a_idle_zero, clk_i, rst_ni, out_valid_i && !playing_i, sample_i == 16'd0)

  // the final sample belongs to a playing cue
  `ATS_ASSERT_NOW(a_last_play, clk_i, rst_ni, out_valid_i && cue_last_i, playing_i)

endmodule

bind alert_tone_sequencer ats_checker u_ats_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (tone_in.valid),
  .in_ready_i  (tone_in.ready),
  .in_func_i   (tone_in.func),
  .out_valid_i (tone_out.valid),
  .out_ready_i (tone_out.ready),
  .sample_i    (tone_out.sample),
  .cue_last_i  (tone_out.cue_last),
  .playing_i   (tone_out.playing)
);
